/* rtl/core/assert_macros.svh */
// Assertion helpers included by the checker file.
// Each macro builds one labeled concurrent assertion on clk_i, held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define NCCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define NCCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/nccr_pkg.sv */
package nccr_pkg;

  // Fixed field widths.
  localparam int VALUE_BITS   = 16;
  localparam int DIST_BITS    = 39;
  localparam int LABEL_BITS   = 8;
  localparam int CI_PORT_BITS = 7;
  localparam int DI_PORT_BITS = 6;
  localparam int DIM_CFG_BITS = 7;
  localparam int CNT_CFG_BITS = 8;
  localparam int CFG_DATA_BITS = 8;
  localparam int CFG_IDX_BITS  = 1;

  // A difference of two components needs one extra bit; its square fits twice that.
  localparam int DIFF_BITS = VALUE_BITS + 1;
  localparam int TERM_BITS = 2 * DIFF_BITS;
  localparam int SUM_BITS  = DIST_BITS + 1;

  // Saturation value of the squared distance.
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_CENTER  = 2'd0,
    OP_RADIUS  = 2'd1,
    OP_EXAMPLE = 2'd2
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DIM_IN_USE    = 1'b0,
    CFG_CLUSTER_COUNT = 1'b1
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_SCAN   = 3'd1,
    ST_DRAIN  = 3'd2,
    ST_LOOKUP = 3'd3,
    ST_REPORT = 3'd4
  } state_e;

endpackage

/* rtl/core/nearest_centroid_radius_classifier_core.sv */
// Nearest-centroid classifier with a squared acceptance radius per cluster.
// Input channel: an item is transferred on a rising edge with start_i high and busy_o low.
// Op center writes one center component, op radius writes a radius and label, op example
// writes one example component; an example component with last_i set starts classification.
// Load items and example components without last_i leave busy_o low.
// Classification scans the clusters in use through one shared subtract-square-accumulate unit,
// one distance term per cycle fed by the center memory read port, then reads the radius
// and label of the winner and registers the result; busy_o stays high until the cycle the
// result is shown. With no clusters in use the scan is skipped.
// Result channel: result_valid_o is high for exactly one cycle with known_o, label_o,
// nearest_index_o and distance_sq_o; the receiver takes it and cannot stall the block.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i at once; it is to be
// written only while the block is idle, and the block itself does not enforce this.
// Reset sets dim_in_use to 1 and cluster_count to 0 and stops any scan. The memories are
// not cleared: a cluster or component is to be written before it is used; the block does not check this.
module nearest_centroid_radius_classifier_core
  import nccr_pkg::*;
#(
  parameter int MAX_CLUSTERS = 128,
  parameter int MAX_DIM      = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [1:0]                     op_i,
  input  logic [CI_PORT_BITS-1:0]        cluster_index_i,
  input  logic [DI_PORT_BITS-1:0]        dim_index_i,
  input  logic signed [VALUE_BITS-1:0]   value_i,
  input  logic [DIST_BITS-1:0]           radius_sq_i,
  input  logic [LABEL_BITS-1:0]          class_label_i,
  input  logic                           last_i,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]        cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]       cfg_data_i,
  output logic                           result_valid_o,
  output logic                           known_o,
  output logic [LABEL_BITS-1:0]          label_o,
  output logic [CI_PORT_BITS-1:0]        nearest_index_o,
  output logic [DIST_BITS-1:0]           distance_sq_o
);

  localparam int CI_W     = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DI_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CC_W     = $clog2(MAX_CLUSTERS + 1);
  localparam int DC_W     = $clog2(MAX_DIM + 1);
  localparam int CM_DEPTH = MAX_CLUSTERS * (2 ** DI_W);
  localparam int EX_DEPTH = 2 ** DI_W;

  // Configuration registers.
  logic [DIM_CFG_BITS-1:0] dim_cfg_q;
  logic [CNT_CFG_BITS-1:0] cnt_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_cfg_q <= DIM_CFG_BITS'(1);
      cnt_cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_DIM_IN_USE:    dim_cfg_q <= cfg_data_i[DIM_CFG_BITS-1:0];
        CFG_CLUSTER_COUNT: cnt_cfg_q <= cfg_data_i[CNT_CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to what the stores hold.
  logic [DC_W-1:0] dims_eff;
  logic [CC_W-1:0] count_eff;

  always_comb begin
    if (dim_cfg_q == '0) begin
      dims_eff = DC_W'(1);
    end else if (32'(dim_cfg_q) > MAX_DIM) begin
      dims_eff = DC_W'(MAX_DIM);
    end else begin
      dims_eff = DC_W'(dim_cfg_q);
    end
    if (32'(cnt_cfg_q) > MAX_CLUSTERS) begin
      count_eff = CC_W'(MAX_CLUSTERS);
    end else begin
      count_eff = CC_W'(cnt_cfg_q);
    end
  end

  // Input transfer decode.
  logic            accept;
  logic            ci_ok;
  logic            di_ok;
  logic [CI_W-1:0] ci_addr;
  logic [DI_W-1:0] di_addr;
  logic            center_we;
  logic            radius_we;
  logic            example_we;
  logic            classify_go;

  assign accept  = start_i && !busy_o;
  assign ci_ok   = 32'(cluster_index_i) < MAX_CLUSTERS;
  assign di_ok   = 32'(dim_index_i) < MAX_DIM;
  assign ci_addr = CI_W'(cluster_index_i);
  assign di_addr = DI_W'(dim_index_i);

  always_comb begin
    center_we   = 1'b0;
    radius_we   = 1'b0;
    example_we  = 1'b0;
    classify_go = 1'b0;
    if (accept) begin
      case (op_e'(op_i))
        OP_CENTER:  center_we = ci_ok && di_ok;
        OP_RADIUS:  radius_we = ci_ok;
        OP_EXAMPLE: begin
          example_we  = di_ok;
          classify_go = last_i;
        end
        default: ;
      endcase
    end
  end

  // Sequencer.
  state_e state_q, state_d;
  logic   issue;
  logic   lookup;
  logic   report;
  logic   pipe_busy;
  logic   last_d;
  logic   last_k;

  logic [DI_W-1:0] d_q, d_d;
  logic [CI_W-1:0] k_q, k_d;

  assign last_d = (32'(d_q) + 1) == 32'(dims_eff);
  assign last_k = (32'(k_q) + 1) == 32'(count_eff);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (classify_go) begin
          state_d = (count_eff == '0) ? ST_LOOKUP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_d && last_k) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_d = ST_REPORT;
      ST_REPORT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (state_q != ST_IDLE);
    issue  = (state_q == ST_SCAN);
    lookup = (state_q == ST_LOOKUP);
    report = (state_q == ST_REPORT);
  end

  // Component and cluster counters walk the center table in order.
  always_comb begin
    d_d = d_q;
    k_d = k_q;
    if (classify_go) begin
      d_d = '0;
      k_d = '0;
    end else if (issue) begin
      if (last_d) begin
        d_d = '0;
        k_d = CI_W'(32'(k_q) + 1);
      end else begin
        d_d = DI_W'(32'(d_q) + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      d_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      d_q     <= d_d;
      k_q     <= k_d;
    end
  end

  // Center store: written by load items, read once per scan cycle.
  logic signed [VALUE_BITS-1:0] center_mem [CM_DEPTH];
  logic signed [VALUE_BITS-1:0] center_rd_q;

  always_ff @(posedge clk_i) begin
    if (center_we) begin
      center_mem[{ci_addr, di_addr}] <= value_i;
    end
    if (issue) begin
      center_rd_q <= center_mem[{k_q, d_q}];
    end
  end

  // Example buffer.
  logic signed [VALUE_BITS-1:0] example_mem [EX_DEPTH];
  logic signed [VALUE_BITS-1:0] example_rd_q;

  always_ff @(posedge clk_i) begin
    if (example_we) begin
      example_mem[di_addr] <= value_i;
    end
    if (issue) begin
      example_rd_q <= example_mem[d_q];
    end
  end

  // Radius and label stores, read once for the winning cluster.
  logic [DIST_BITS-1:0]  radius_mem [MAX_CLUSTERS];
  logic [LABEL_BITS-1:0] label_mem  [MAX_CLUSTERS];
  logic [DIST_BITS-1:0]  radius_rd_q;
  logic [LABEL_BITS-1:0] label_rd_q;

  always_ff @(posedge clk_i) begin
    if (radius_we) begin
      radius_mem[ci_addr] <= radius_sq_i;
      label_mem[ci_addr]  <= class_label_i;
    end
  end

  // Stage tags travel alongside the data through read, square and accumulate.
  logic            p1_vld_q, p2_vld_q, p3_vld_q;
  logic            p1_first_q, p2_first_q;
  logic            p1_last_q, p2_last_q, p3_last_q;
  logic [CI_W-1:0] p1_k_q, p2_k_q, p3_k_q;

  assign pipe_busy = p1_vld_q || p2_vld_q || p3_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= issue;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_first_q <= (d_q == '0);
    p1_last_q  <= last_d;
    p1_k_q     <= k_q;
    p2_first_q <= p1_first_q;
    p2_last_q  <= p1_last_q;
    p2_k_q     <= p1_k_q;
    p3_last_q  <= p2_last_q;
    p3_k_q     <= p2_k_q;
  end

  // Shared unit, first half: difference, magnitude and square.
  logic signed [DIFF_BITS-1:0] diff;
  logic [DIFF_BITS-1:0]        mag;
  logic [TERM_BITS-1:0]        term_q;

  assign diff = DIFF_BITS'(example_rd_q) - DIFF_BITS'(center_rd_q);
  assign mag  = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);

  always_ff @(posedge clk_i) begin
    if (p1_vld_q) begin
      term_q <= mag * mag;
    end
  end

  // Shared unit, second half: saturating accumulation of one cluster's terms.
  logic [DIST_BITS-1:0] acc_q, acc_d;
  logic [DIST_BITS-1:0] acc_base;
  logic [SUM_BITS-1:0]  acc_sum;

  always_comb begin
    acc_base = p2_first_q ? '0 : acc_q;
    acc_sum  = SUM_BITS'(acc_base) + SUM_BITS'(term_q);
    if (acc_sum >= SUM_BITS'(DIST_MAX)) begin
      acc_d = DIST_MAX;
    end else begin
      acc_d = acc_sum[DIST_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_vld_q) begin
      acc_q <= acc_d;
    end
  end

  // Running best: a later cluster wins a tie.
  logic                 found_q;
  logic [DIST_BITS-1:0] best_d_q;
  logic [CI_W-1:0]      best_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= 1'b0;
      best_d_q <= DIST_MAX;
      best_k_q <= '0;
    end else if (classify_go) begin
      found_q  <= 1'b0;
      best_d_q <= DIST_MAX;
      best_k_q <= '0;
    end else if (p3_vld_q && p3_last_q && (!found_q || acc_q <= best_d_q)) begin
      found_q  <= 1'b1;
      best_d_q <= acc_q;
      best_k_q <= p3_k_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lookup) begin
      radius_rd_q <= radius_mem[best_k_q];
      label_rd_q  <= label_mem[best_k_q];
    end
  end

  // Result register, shown for one cycle.
  logic                    res_vld_q;
  logic                    known_q;
  logic [LABEL_BITS-1:0]   label_q;
  logic [CI_PORT_BITS-1:0] index_q;
  logic [DIST_BITS-1:0]    dist_q;
  logic                    known_d;

  assign known_d = found_q && (best_d_q <= radius_rd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= report;
    end
  end

  always_ff @(posedge clk_i) begin
    if (report) begin
      known_q <= known_d;
      label_q <= known_d ? label_rd_q : '0;
      index_q <= CI_PORT_BITS'(best_k_q);
      dist_q  <= best_d_q;
    end
  end

  assign result_valid_o  = res_vld_q;
  assign known_o         = known_q;
  assign label_o         = label_q;
  assign nearest_index_o = index_q;
  assign distance_sq_o   = dist_q;

endmodule

/* rtl/core/nccr_checker.sv */
`include "assert_macros.svh"

// Port-level checks of the classifier core.
module nccr_checker
  import nccr_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_o,
  input logic [1:0]           op_i,
  input logic                 last_i,
  input logic                 result_valid_o,
  input logic                 known_o,
  input logic [LABEL_BITS-1:0] label_o
);

  // A result appears only once the scan has let go of the input side.
  `NCCR_ASSERT_NOW(a_result_when_idle, result_valid_o, !busy_o && $past(busy_o), "result strobe without a preceding classification")

  // An unknown result carries no label.
  `NCCR_ASSERT_NOW(a_unknown_no_label, result_valid_o && !known_o, label_o == '0, "unknown result with a nonzero label")

  // The last example component starts a classification.
  `NCCR_ASSERT_NXT(a_last_starts, start_i && !busy_o && op_i == OP_EXAMPLE && last_i, busy_o, "last component transfer did not start classification")

  // Any other transfer does not make the block busy.
  `NCCR_ASSERT_NXT(a_load_no_busy, start_i && !busy_o && !(op_i == OP_EXAMPLE && last_i), !busy_o, "load transfer made the block busy")

  // Each result strobe lasts one cycle.
  `NCCR_ASSERT_NXT(a_strobe_single, result_valid_o, !result_valid_o, "result strobe held for more than one cycle")

endmodule

bind nearest_centroid_radius_classifier_core nccr_checker u_nccr_checker (.*);
